### design/sfp_module_bringup_fsm_unit_defines.svh
// Assertion macros for the checker file of the bring-up sequencer.
`ifndef SFP_MODULE_BRINGUP_FSM_UNIT_DEFINES_SVH
`define SFP_MODULE_BRINGUP_FSM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SFPBU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfpbu: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SFPBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfpbu: next-cycle check failed");

`endif

### design/sfpbu_pkg.sv
package sfpbu_pkg;

  // Module count and the part of it that the scan covers.
  localparam int NUM_MODULES = 32;
  localparam int MAX_MODULES = 32;
  localparam int SCAN_COUNT  = (NUM_MODULES < MAX_MODULES) ? NUM_MODULES : MAX_MODULES;

  // Field widths.
  localparam int MOD_IDX_W = 5;
  localparam int STATE_W   = 4;
  localparam int DELAY_W   = 11;
  localparam int REQ_W     = 2;
  localparam int CMD_W     = 2;
  localparam int BITS_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [MOD_IDX_W:0]   SCAN_LIMIT = (MOD_IDX_W + 1)'(SCAN_COUNT);
  localparam logic [MOD_IDX_W-1:0] SCAN_LAST  = MOD_IDX_W'(SCAN_COUNT - 1);

  // Register reset values.
  localparam logic               LOS_POLL_EN_RST = 1'b1;
  localparam logic [DELAY_W-1:0] RESET_PULSE_RST = DELAY_W'(2);
  localparam logic [DELAY_W-1:0] T_RESET_RST     = DELAY_W'(2000);
  localparam logic [DELAY_W-1:0] TXDIS_RST       = DELAY_W'(100);
  localparam logic [DELAY_W-1:0] SETTLE_RST      = DELAY_W'(200);
  localparam logic [DELAY_W-1:0] RXLOS_POLL_RST  = DELAY_W'(100);

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE           = 4'd0,
    ST_REMOVED        = 4'd1,
    ST_INSERTED       = 4'd2,
    ST_WAIT_T_RESET   = 4'd3,
    ST_WAIT_TON_TXDIS = 4'd4,
    ST_DETECTED       = 4'd5,
    ST_UPDATE         = 4'd6,
    ST_WAIT_UPDATE    = 4'd7,
    ST_DISABLED       = 4'd8,
    ST_ENABLING       = 4'd9,
    ST_ENA_OPTICAL_TX = 4'd10,
    ST_NOTIFY_ENABLED = 4'd11,
    ST_ENABLED        = 4'd12,
    ST_DISABLING      = 4'd13
  } mod_state_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2
  } req_e;

  typedef enum logic [CMD_W-1:0] {
    RST_NONE     = 2'd0,
    RST_ASSERT   = 2'd1,
    RST_DEASSERT = 2'd2
  } rst_cmd_e;

  typedef enum logic [CMD_W-1:0] {
    TXD_NONE  = 2'd0,
    TXD_SET   = 2'd1,
    TXD_CLEAR = 2'd2
  } txd_cmd_e;

  typedef enum logic [CMD_W-1:0] {
    NTF_NONE      = 2'd0,
    NTF_READY     = 2'd1,
    NTF_NOT_READY = 2'd2,
    NTF_REMOVED   = 2'd3
  } notify_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOS_POLL_EN = 3'd0,
    CFG_RESET_PULSE = 3'd1,
    CFG_T_RESET     = 3'd2,
    CFG_TXDIS       = 3'd3,
    CFG_SETTLE      = 3'd4,
    CFG_RXLOS_POLL  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EVENT,
    SEQ_SCAN,
    SEQ_FLUSH
  } seq_state_e;

  typedef struct packed {
    logic               los_poll_en;
    logic [DELAY_W-1:0] reset_pulse;
    logic [DELAY_W-1:0] t_reset;
    logic [DELAY_W-1:0] txdis;
    logic [DELAY_W-1:0] settle;
    logic [DELAY_W-1:0] rxlos_poll;
  } cfg_t;

  // One module's stored record.
  typedef struct packed {
    mod_state_e         state;
    logic [DELAY_W-1:0] remaining;
    logic               quick_removed;
  } entry_t;

  // What the step unit hands back to the sequencer.
  typedef struct packed {
    logic     do_step;
    entry_t   wr_entry;
    rst_cmd_e rst_cmd;
    txd_cmd_e txd_cmd;
    notify_e  notify;
  } step_res_t;

  // One result word, without its last mark.
  typedef struct packed {
    logic [MOD_IDX_W-1:0] module_idx;
    logic                 stepped;
    mod_state_e           prev_state;
    mod_state_e           next_state;
    rst_cmd_e             rst_cmd;
    txd_cmd_e             txd_cmd;
    notify_e              notify;
    logic                 quick_removed;
  } result_t;

endpackage

### design/sfpbu_store.sv
module sfpbu_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [sfpbu_pkg::MOD_IDX_W-1:0] rd_addr_i,
  output sfpbu_pkg::entry_t               rd_entry_o,
  input  logic                            wr_en_i,
  input  logic [sfpbu_pkg::MOD_IDX_W-1:0] wr_addr_i,
  input  sfpbu_pkg::entry_t               wr_entry_i
);
  import sfpbu_pkg::*;

  entry_t entry_q [MAX_MODULES];

  // Every module starts idle with no delay and no quick-removal mark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_MODULES; i++) begin
        entry_q[i] <= '{state: ST_IDLE, remaining: '0, quick_removed: 1'b0};
      end
    end else if (wr_en_i) begin
      entry_q[wr_addr_i] <= wr_entry_i;
    end
  end

  assign rd_entry_o = entry_q[rd_addr_i];

endmodule

### design/sfpbu_step.sv
module sfpbu_step (
  input  sfpbu_pkg::cfg_t      cfg_i,
  input  sfpbu_pkg::entry_t    entry_i,
  input  logic                 los_i,
  input  logic                 present_i,
  input  logic                 status_ok_i,
  output sfpbu_pkg::step_res_t res_o
);
  import sfpbu_pkg::*;

  logic [DELAY_W-1:0] rem_dec;
  logic               qr_poll;
  logic               poll_gone;
  logic               los_level;

  // One millisecond off the delay, floored at zero.
  assign rem_dec = (entry_i.remaining != '0) ? entry_i.remaining - DELAY_W'(1) : '0;

  // A latched mark, or a failed read from an absent module, means the module is gone.
  always_comb begin
    qr_poll   = entry_i.quick_removed;
    poll_gone = 1'b0;
    los_level = 1'b0;
    if (entry_i.quick_removed) begin
      poll_gone = 1'b1;
    end else if (!status_ok_i) begin
      if (!present_i) begin
        qr_poll   = 1'b1;
        poll_gone = 1'b1;
      end
    end else begin
      los_level = los_i;
    end
  end

  // State step for a module whose delay has run out.
  always_comb begin
    res_o                        = '0;
    res_o.do_step                = (entry_i.state != ST_IDLE) && (rem_dec == '0);
    res_o.wr_entry.state         = entry_i.state;
    res_o.wr_entry.remaining     = rem_dec;
    res_o.wr_entry.quick_removed = entry_i.quick_removed;
    res_o.rst_cmd                = RST_NONE;
    res_o.txd_cmd                = TXD_NONE;
    res_o.notify                 = NTF_NONE;
    if (res_o.do_step) begin
      res_o.wr_entry.remaining = '0;
      case (entry_i.state)
        ST_REMOVED: begin
          res_o.rst_cmd                = RST_DEASSERT;
          res_o.txd_cmd                = TXD_SET;
          res_o.notify                 = NTF_REMOVED;
          res_o.wr_entry.quick_removed = 1'b0;
          res_o.wr_entry.state         = ST_IDLE;
        end
        ST_INSERTED: begin
          res_o.rst_cmd                = RST_ASSERT;
          res_o.wr_entry.quick_removed = 1'b0;
          res_o.wr_entry.state         = ST_WAIT_T_RESET;
          res_o.wr_entry.remaining     = cfg_i.reset_pulse;
        end
        ST_WAIT_T_RESET: begin
          res_o.rst_cmd            = RST_DEASSERT;
          res_o.wr_entry.state     = ST_WAIT_TON_TXDIS;
          res_o.wr_entry.remaining = cfg_i.t_reset;
        end
        ST_WAIT_TON_TXDIS: begin
          res_o.txd_cmd            = TXD_SET;
          res_o.wr_entry.state     = ST_DETECTED;
          res_o.wr_entry.remaining = cfg_i.txdis;
        end
        ST_DETECTED: begin
          res_o.wr_entry.state     = ST_ENA_OPTICAL_TX;
          res_o.wr_entry.remaining = cfg_i.settle;
        end
        ST_ENA_OPTICAL_TX: begin
          res_o.txd_cmd            = TXD_CLEAR;
          res_o.wr_entry.state     = ST_ENABLING;
          res_o.wr_entry.remaining = cfg_i.txdis;
        end
        ST_ENABLING: begin
          res_o.wr_entry.state     = ST_NOTIFY_ENABLED;
          res_o.wr_entry.remaining = cfg_i.settle;
          if (cfg_i.los_poll_en) begin
            res_o.wr_entry.quick_removed = qr_poll;
            if (poll_gone) begin
              res_o.wr_entry.state = ST_DISABLING;
            end else if (los_level) begin
              res_o.wr_entry.state = ST_ENABLING;
            end
          end
        end
        ST_NOTIFY_ENABLED: begin
          res_o.notify             = NTF_READY;
          res_o.wr_entry.state     = ST_ENABLED;
          res_o.wr_entry.remaining = cfg_i.settle;
        end
        ST_ENABLED: begin
          res_o.wr_entry.state     = ST_ENABLED;
          res_o.wr_entry.remaining = cfg_i.rxlos_poll;
          if (cfg_i.los_poll_en) begin
            res_o.wr_entry.quick_removed = qr_poll;
            if (poll_gone || los_level) begin
              res_o.wr_entry.state = ST_DISABLING;
            end
          end
        end
        ST_DISABLING: begin
          res_o.notify             = NTF_NOT_READY;
          res_o.wr_entry.state     = ST_DISABLED;
          res_o.wr_entry.remaining = cfg_i.settle;
        end
        ST_DISABLED: begin
          res_o.wr_entry.state     = ST_ENABLING;
          res_o.wr_entry.remaining = cfg_i.settle;
        end
        ST_UPDATE: begin
          res_o.wr_entry.state = ST_WAIT_UPDATE;
        end
        ST_WAIT_UPDATE: begin
          res_o.wr_entry.state = ST_DETECTED;
        end
        default: begin
          res_o.wr_entry.state = ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/sfp_module_bringup_fsm_unit.sv
// Insert and remove events each give a single result word.
// A tick scans SCAN_COUNT module records: the shared step unit visits one
// module record a cycle, and the last word is built in the flush state after the scan ends.
// Results appear one per cycle at most; the receiver cannot stall, so none are held.
// Reset is asynchronous, active low: all modules idle, delays and marks cleared,
// registers at their defaults, the block ready at once.
module sfp_module_bringup_fsm_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [sfpbu_pkg::REQ_W-1:0]     req_type_i,
  input  logic [sfpbu_pkg::MOD_IDX_W-1:0] module_index_i,
  input  logic [sfpbu_pkg::BITS_W-1:0]    los_bits_i,
  input  logic [sfpbu_pkg::BITS_W-1:0]    present_bits_i,
  input  logic [sfpbu_pkg::BITS_W-1:0]    status_ok_bits_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfpbu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sfpbu_pkg::DELAY_W-1:0]   cfg_data_i,
  output logic                            result_valid_o,
  output logic [sfpbu_pkg::MOD_IDX_W-1:0] out_module_o,
  output logic                            stepped_o,
  output logic [sfpbu_pkg::STATE_W-1:0]   prev_state_o,
  output logic [sfpbu_pkg::STATE_W-1:0]   next_state_o,
  output logic [sfpbu_pkg::CMD_W-1:0]     reset_cmd_o,
  output logic [sfpbu_pkg::CMD_W-1:0]     txdis_cmd_o,
  output logic [sfpbu_pkg::CMD_W-1:0]     port_notify_o,
  output logic                            quick_removed_flag_o,
  output logic                            last_o
);
  import sfpbu_pkg::*;

  seq_state_e           seq_q, seq_d;
  cfg_t                 cfg_q;
  req_e                 req_q;
  logic [MOD_IDX_W-1:0] mod_q;
  logic [BITS_W-1:0]    los_q, present_q, ok_q;
  logic [MOD_IDX_W-1:0] idx_q, idx_d;
  result_t              pend_q, pend_d;
  logic                 pend_valid_q, pend_valid_d;
  result_t              res_q, res_d;
  logic                 res_valid_q, res_valid_d;
  logic                 res_last_q, res_last_d;

  logic                 accept;
  logic                 cfg_write;
  logic [MOD_IDX_W-1:0] rd_addr;
  entry_t               rd_entry;
  logic                 wr_en;
  entry_t               wr_entry;
  step_res_t            step;
  result_t              step_word;
  result_t              event_word;
  mod_state_e           event_state;

  assign accept      = start_i && (seq_q == SEQ_IDLE);
  assign busy_o      = (seq_q != SEQ_IDLE);
  assign cfg_ready_o = (seq_q == SEQ_IDLE);
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.los_poll_en <= LOS_POLL_EN_RST;
      cfg_q.reset_pulse <= RESET_PULSE_RST;
      cfg_q.t_reset     <= T_RESET_RST;
      cfg_q.txdis       <= TXDIS_RST;
      cfg_q.settle      <= SETTLE_RST;
      cfg_q.rxlos_poll  <= RXLOS_POLL_RST;
    end else if (cfg_write) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOS_POLL_EN: cfg_q.los_poll_en <= cfg_data_i[0];
        CFG_RESET_PULSE: cfg_q.reset_pulse <= cfg_data_i;
        CFG_T_RESET:     cfg_q.t_reset     <= cfg_data_i;
        CFG_TXDIS:       cfg_q.txdis       <= cfg_data_i;
        CFG_SETTLE:      cfg_q.settle      <= cfg_data_i;
        CFG_RXLOS_POLL:  cfg_q.rxlos_poll  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Module record store and the shared step unit.
  assign rd_addr = (seq_q == SEQ_EVENT) ? mod_q : idx_q;

  sfpbu_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (rd_addr),
    .wr_entry_i (wr_entry)
  );

  sfpbu_step u_step (
    .cfg_i       (cfg_q),
    .entry_i     (rd_entry),
    .los_i       (los_q[idx_q]),
    .present_i   (present_q[idx_q]),
    .status_ok_i (ok_q[idx_q]),
    .res_o       (step)
  );

  // Result words built from the step unit and from an event.
  assign event_state = (req_q == REQ_INSERT) ? ST_INSERTED : ST_REMOVED;

  always_comb begin
    step_word.module_idx    = idx_q;
    step_word.stepped       = 1'b1;
    step_word.prev_state    = rd_entry.state;
    step_word.next_state    = step.wr_entry.state;
    step_word.rst_cmd       = step.rst_cmd;
    step_word.txd_cmd       = step.txd_cmd;
    step_word.notify        = step.notify;
    step_word.quick_removed = step.wr_entry.quick_removed;

    event_word.module_idx    = mod_q;
    event_word.stepped       = 1'b1;
    event_word.prev_state    = rd_entry.state;
    event_word.next_state    = event_state;
    event_word.rst_cmd       = RST_NONE;
    event_word.txd_cmd       = TXD_NONE;
    event_word.notify        = NTF_NONE;
    event_word.quick_removed = rd_entry.quick_removed;
  end

  // Sequencer next state.
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          case (req_e'(req_type_i))
            REQ_INSERT, REQ_REMOVE: begin
              seq_d = ({1'b0, module_index_i} < SCAN_LIMIT) ? SEQ_EVENT : SEQ_FLUSH;
            end
            REQ_TICK: seq_d = SEQ_SCAN;
            default:  seq_d = SEQ_FLUSH;
          endcase
        end
      end
      SEQ_EVENT: seq_d = SEQ_FLUSH;
      SEQ_SCAN: begin
        if (idx_q == SCAN_LAST) begin
          seq_d = SEQ_FLUSH;
        end
      end
      SEQ_FLUSH: seq_d = SEQ_IDLE;
      default:   seq_d = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: store writes, the held word and the result register.
  // A stepped word is held back one step so that the final one can carry last.
  always_comb begin
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    res_last_d   = 1'b0;
    wr_en        = 1'b0;
    wr_entry     = step.wr_entry;
    case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          idx_d        = '0;
          pend_valid_d = 1'b0;
        end
      end
      SEQ_EVENT: begin
        wr_en                  = 1'b1;
        wr_entry.state         = event_state;
        wr_entry.remaining     = '0;
        wr_entry.quick_removed = rd_entry.quick_removed;
        pend_d                 = event_word;
        pend_valid_d           = 1'b1;
      end
      SEQ_SCAN: begin
        wr_en = 1'b1;
        idx_d = idx_q + MOD_IDX_W'(1);
        if (step.do_step) begin
          pend_d       = step_word;
          pend_valid_d = 1'b1;
          if (pend_valid_q) begin
            res_d       = pend_q;
            res_valid_d = 1'b1;
          end
        end
      end
      SEQ_FLUSH: begin
        res_valid_d = 1'b1;
        res_last_d  = 1'b1;
        res_d       = pend_valid_q ? pend_q : '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= SEQ_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      seq_q        <= seq_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_e'(req_type_i);
      mod_q     <= module_index_i;
      los_q     <= los_bits_i;
      present_q <= present_bits_i;
      ok_q      <= status_ok_bits_i;
    end
    pend_q     <= pend_d;
    res_q      <= res_d;
    res_last_q <= res_last_d;
  end

  assign result_valid_o       = res_valid_q;
  assign out_module_o         = res_q.module_idx;
  assign stepped_o            = res_q.stepped;
  assign prev_state_o         = res_q.prev_state;
  assign next_state_o         = res_q.next_state;
  assign reset_cmd_o          = res_q.rst_cmd;
  assign txdis_cmd_o          = res_q.txd_cmd;
  assign port_notify_o        = res_q.notify;
  assign quick_removed_flag_o = res_q.quick_removed;
  assign last_o               = res_last_q;

endmodule

### design/sfpbu_checker.sv
`include "sfp_module_bringup_fsm_unit_defines.svh"

module sfpbu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            result_valid_o,
  input logic [sfpbu_pkg::MOD_IDX_W-1:0] out_module_o,
  input logic                            stepped_o,
  input logic [sfpbu_pkg::STATE_W-1:0]   prev_state_o,
  input logic [sfpbu_pkg::STATE_W-1:0]   next_state_o,
  input logic                            last_o
);
  import sfpbu_pkg::*;

  // An accepted request keeps the block busy in the following cycle.
  `SFPBU_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)

  // Words before the final one only appear while the block is still busy.
  `SFPBU_ASSERT_SAME(a_early_word_busy, result_valid_o && !last_o, busy_o)

  // The block only goes idle together with the final word of the item.
  `SFPBU_ASSERT_SAME(a_idle_with_last, $fell(busy_o), result_valid_o && last_o)

  // A word that applied nothing is the all-zero final word.
  `SFPBU_ASSERT_SAME(a_null_word, result_valid_o && !stepped_o,
    last_o && (out_module_o == '0) && (prev_state_o == '0) && (next_state_o == '0))

endmodule

bind sfp_module_bringup_fsm_unit sfpbu_checker u_sfpbu_checker (.*);
